>>> hw/rtl/qat_pkg.sv
// Shared constants and types for the quoted argument tokenizer.
`default_nettype none

package qat_pkg;

    // Default limit on the number of arguments in one line.
    localparam int MAX_ARGS_DEFAULT = 16;

    // Configuration register indexes and port width.
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ESCAPE_CHAR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_QUOTE_CHAR  = 2'd1;

    // Register reset values: backslash and double quote.
    localparam logic [7:0] ESCAPE_CHAR_RESET = 8'd92;
    localparam logic [7:0] QUOTE_CHAR_RESET  = 8'd34;

    // Input operation codes.
    localparam logic OP_CHAR     = 1'b0;
    localparam logic OP_LINE_END = 1'b1;

    // Result kinds.
    localparam logic [1:0] KIND_CHAR     = 2'd0;
    localparam logic [1:0] KIND_ARG_END  = 2'd1;
    localparam logic [1:0] KIND_LINE_END = 2'd2;

    // One result as produced by the tokenizer core.
    typedef struct packed {
        logic       emit;
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] arg_index;
        logic       first;
        logic [4:0] arg_count;
    } result_t;

endpackage

`default_nettype wire

>>> hw/rtl/quoted_argument_tokenizer_unit.sv
// Top level of the quoted argument tokenizer: handshakes, registers and result stage.
`default_nettype none

// Splits a command line, fed one byte per transaction, into arguments. Each
// transaction on the item channel is either a character (op = 0) or a line end
// (op = 1). Argument bytes come out with their argument index and a first
// flag, whitespace that closes an argument gives an end marker, and a line end
// gives the final argument count and clears the tokenizer. The block takes one
// item per clock cycle while results are not stalled; an item passes an input
// register and a result register; its result is shown once the item has moved
// into the result register. That rate is set by the tokenizer state update
// between those two registers. A stalled result holds the input register, and
// the item channel stalls once both are full. Escape and quote bytes are set
// through the configuration channel (index 0 escape, index 1 quote); the user
// must set them only while the block is idle, which the block does not enforce.
module quoted_argument_tokenizer_unit #(
    parameter int MAX_ARGS = qat_pkg::MAX_ARGS_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Item channel
    input  wire logic                            item_valid,
    output logic                                 item_stall,
    input  wire logic                            op,
    input  wire logic [7:0]                      ch,
    // Result channel
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output logic [1:0]                           kind,
    output logic [7:0]                           data,
    output logic [3:0]                           arg_index,
    output logic                                 first,
    output logic [4:0]                           arg_count,
    // Configuration channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [qat_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                      cfg_data
);

    logic             s1_valid_reg;
    logic             s1_op_reg;
    logic [7:0]       s1_ch_reg;
    logic [7:0]       escape_reg;
    logic [7:0]       quote_reg;
    logic             result_valid_reg;
    qat_pkg::result_t result_reg;
    qat_pkg::result_t core_result;
    logic             out_free;
    logic             advance;
    logic             item_accept;

    // The input register moves on when the result stage can take its result.
    assign out_free    = !result_valid_reg || !result_stall;
    assign advance     = s1_valid_reg && out_free;
    assign item_stall  = s1_valid_reg && !advance;
    assign item_accept = item_valid && !item_stall;
    assign cfg_ready   = 1'b1;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            s1_op_reg <= op;
            s1_ch_reg <= ch;
        end
    end

    // Configuration registers; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg <= qat_pkg::ESCAPE_CHAR_RESET;
            quote_reg  <= qat_pkg::QUOTE_CHAR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                qat_pkg::CFG_ESCAPE_CHAR: escape_reg <= cfg_data;
                qat_pkg::CFG_QUOTE_CHAR:  quote_reg  <= cfg_data;
                default:                  ;
            endcase
        end
    end

    qat_core #(
        .MAX_ARGS    (MAX_ARGS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .op          (s1_op_reg),
        .ch          (s1_ch_reg),
        .escape_char (escape_reg),
        .quote_char  (quote_reg),
        .result      (core_result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= core_result.emit;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && core_result.emit)
        begin
            result_reg <= core_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign kind         = result_reg.kind;
    assign data         = result_reg.data;
    assign arg_index    = result_reg.arg_index;
    assign first        = result_reg.first;
    assign arg_count    = result_reg.arg_count;

`ifndef SYNTHESIS
    // A processed line end always shows up as a line end result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_op_reg == qat_pkg::OP_LINE_END)
        |=> (result_valid && kind == qat_pkg::KIND_LINE_END))
        else $error("line end produced no line end result");

    // Only argument bytes carry data or the first flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind != qat_pkg::KIND_CHAR) |-> (data == 8'd0 && !first))
        else $error("marker result carries data or first flag");

    // A held input item stays in place until the result stage frees up.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance)
        |=> (s1_valid_reg && $stable(s1_ch_reg) && $stable(s1_op_reg)))
        else $error("input register lost a held item");

    // An item is processed only when the result stage has room.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> (!result_valid_reg || !result_stall))
        else $error("item processed into a stalled result stage");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/qat_core.sv
// Tokenizer state and the per-character decode that produces at most one result.
`default_nettype none

module qat_core #(
    parameter int MAX_ARGS = qat_pkg::MAX_ARGS_DEFAULT
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire logic             op,
    input  wire logic [7:0]       ch,
    input  wire logic [7:0]       escape_char,
    input  wire logic [7:0]       quote_char,
    output qat_pkg::result_t      result
);

    localparam int CNT_W = $clog2(MAX_ARGS + 1);
    localparam int EXT_W = (CNT_W > 5) ? CNT_W : 5;
    localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_ARGS);

    typedef enum logic [1:0] {
        MODE_PLAIN,
        MODE_ESC,
        MODE_QUOTE,
        MODE_QESC
    } mode_t;

    mode_t            mode_reg, mode_next;
    logic             open_reg, open_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic             emit;
    logic [1:0]       kind;
    logic [7:0]       data;
    logic             first;
    logic             is_space;
    logic             take_byte;
    logic [CNT_W-1:0] cnt_sel;
    logic [EXT_W-1:0] cnt_ext;
    logic [EXT_W-1:0] idx_ext;

    // Whitespace: space, tab, line feed, vertical tab, form feed, carriage return.
    assign is_space = (ch == 8'd32) || ((ch >= 8'd9) && (ch <= 8'd13));

    // Next state and result for the item in the input register.
    always_comb
    begin
        mode_next = mode_reg;
        open_next = open_reg;
        cnt_next  = cnt_reg;
        emit      = 1'b0;
        kind      = qat_pkg::KIND_CHAR;
        data      = ch;
        first     = 1'b0;
        take_byte = 1'b0;
        if (op == qat_pkg::OP_LINE_END)
        begin
            emit      = 1'b1;
            kind      = qat_pkg::KIND_LINE_END;
            data      = 8'd0;
            mode_next = MODE_PLAIN;
            open_next = 1'b0;
            cnt_next  = '0;
        end
        else if (cnt_reg < LIMIT)
        begin
            case (mode_reg)
                MODE_PLAIN:
                begin
                    if (ch == escape_char)
                    begin
                        mode_next = MODE_ESC;
                    end
                    else if (ch == quote_char)
                    begin
                        mode_next = MODE_QUOTE;
                    end
                    else if (is_space)
                    begin
                        if (open_reg)
                        begin
                            emit      = 1'b1;
                            kind      = qat_pkg::KIND_ARG_END;
                            data      = 8'd0;
                            open_next = 1'b0;
                        end
                    end
                    else
                    begin
                        take_byte = 1'b1;
                    end
                end
                MODE_ESC:
                begin
                    mode_next = MODE_PLAIN;
                    take_byte = 1'b1;
                end
                MODE_QUOTE:
                begin
                    if (ch == escape_char)
                    begin
                        mode_next = MODE_QESC;
                    end
                    else if (ch == quote_char)
                    begin
                        mode_next = MODE_PLAIN;
                    end
                    else
                    begin
                        take_byte = 1'b1;
                    end
                end
                default:
                begin
                    mode_next = MODE_QUOTE;
                    take_byte = 1'b1;
                end
            endcase
            // A literal byte opens a new argument when none is open.
            if (take_byte)
            begin
                emit = 1'b1;
                if (!open_reg)
                begin
                    open_next = 1'b1;
                    cnt_next  = cnt_reg + CNT_W'(1);
                    first     = 1'b1;
                end
            end
        end
    end

    // Counts shown on the result: the final count for a line end, else the updated one.
    assign cnt_sel = (op == qat_pkg::OP_LINE_END) ? cnt_reg : cnt_next;
    assign cnt_ext = EXT_W'(cnt_sel);
    assign idx_ext = cnt_ext - EXT_W'(1);

    always_comb
    begin
        result.emit      = emit;
        result.kind      = kind;
        result.data      = data;
        result.first     = first;
        result.arg_count = cnt_ext[4:0];
        result.arg_index = (kind == qat_pkg::KIND_LINE_END) ? 4'd0 : idx_ext[3:0];
    end

    // Tokenizer state, updated once per processed item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_PLAIN;
            open_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            open_reg <= open_next;
            cnt_reg  <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    // The argument count never passes the limit.
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= LIMIT)
        else $error("argument count above limit");

    // A step at the limit with a character leaves the state untouched.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && op == qat_pkg::OP_CHAR && cnt_reg == LIMIT)
        |=> (cnt_reg == LIMIT && $stable(mode_reg) && $stable(open_reg)))
        else $error("state changed past the argument limit");

    // A line end clears the tokenizer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (step && op == qat_pkg::OP_LINE_END)
        |=> (cnt_reg == '0 && !open_reg && mode_reg == MODE_PLAIN))
        else $error("line end did not clear the tokenizer");
`endif

endmodule

`default_nettype wire

>>> tb/tokenizer_checker.sv
// Checker for the quoted argument tokenizer: watches all channels, predicts results, compares.
module tokenizer_checker #(
    parameter int MAX_ARGS = qat_pkg::MAX_ARGS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    input  logic                            item_stall,
    input  logic                            op,
    input  logic [7:0]                      ch,
    input  logic                            result_valid,
    input  logic                            result_stall,
    input  logic [1:0]                      kind,
    input  logic [7:0]                      data,
    input  logic [3:0]                      arg_index,
    input  logic                            first,
    input  logic [4:0]                      arg_count,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [qat_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]                      cfg_data,
    output int                              fail_count,
    output int                              pending
);

    // Lexer position within the line.
    typedef enum logic [1:0] {
        LEX_PLAIN,
        LEX_ESCAPED,
        LEX_QUOTED,
        LEX_QUOTED_ESCAPED
    } lex_mode_e;

    // One expected result transaction.
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [3:0] arg_index;
        logic       first;
        logic [4:0] arg_count;
    } token_t;

    logic [7:0] escape_byte;
    logic [7:0] quote_byte;
    lex_mode_e  lex_mode;
    bit         arg_open;
    int         started_args;
    token_t     expected_tokens[$];
    token_t     next_token;
    token_t     oldest;

    function automatic bit is_blank(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // Builds a result from the current argument count.
    function automatic token_t make_token(input logic [1:0] k, input logic [7:0] d,
                                          input logic f);
        token_t t;
        int     idx;
        idx = started_args > 0 ? started_args - 1 : 0;
        t.kind = k;
        t.data = d;
        t.arg_index = (k == qat_pkg::KIND_LINE_END) ? 4'd0 : idx[3:0];
        t.first = f;
        t.arg_count = started_args[4:0];
        return t;
    endfunction

    // A literal byte opens a new argument when none is open.
    function automatic token_t literal_token(input logic [7:0] c);
        logic f;
        f = 1'b0;
        if (!arg_open)
        begin
            arg_open = 1'b1;
            started_args++;
            f = 1'b1;
        end
        return make_token(qat_pkg::KIND_CHAR, c, f);
    endfunction

    // Advances the tokenizer by one item; returns 1 when the item gives a result.
    function automatic bit tokenize(input logic o, input logic [7:0] c, output token_t t);
        t = '0;
        if (o == qat_pkg::OP_LINE_END)
        begin
            t = make_token(qat_pkg::KIND_LINE_END, 8'd0, 1'b0);
            lex_mode = LEX_PLAIN;
            arg_open = 1'b0;
            started_args = 0;
            return 1'b1;
        end
        // Once the argument count reaches the limit, the rest of the line is dropped.
        if (started_args >= MAX_ARGS)
            return 1'b0;
        case (lex_mode)
            LEX_PLAIN:
            begin
                // The escape meaning is tested before the quote meaning.
                if (c == escape_byte)
                begin
                    lex_mode = LEX_ESCAPED;
                    return 1'b0;
                end
                if (c == quote_byte)
                begin
                    lex_mode = LEX_QUOTED;
                    return 1'b0;
                end
                if (is_blank(c))
                begin
                    if (!arg_open)
                        return 1'b0;
                    t = make_token(qat_pkg::KIND_ARG_END, 8'd0, 1'b0);
                    arg_open = 1'b0;
                    return 1'b1;
                end
                t = literal_token(c);
                return 1'b1;
            end
            LEX_ESCAPED:
            begin
                lex_mode = LEX_PLAIN;
                t = literal_token(c);
                return 1'b1;
            end
            LEX_QUOTED:
            begin
                if (c == escape_byte)
                begin
                    lex_mode = LEX_QUOTED_ESCAPED;
                    return 1'b0;
                end
                if (c == quote_byte)
                begin
                    lex_mode = LEX_PLAIN;
                    return 1'b0;
                end
                t = literal_token(c);
                return 1'b1;
            end
            default:
            begin
                lex_mode = LEX_QUOTED;
                t = literal_token(c);
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // Everything is sampled at the rising edge, before the block's registers update.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_byte = qat_pkg::ESCAPE_CHAR_RESET;
            quote_byte = qat_pkg::QUOTE_CHAR_RESET;
            lex_mode = LEX_PLAIN;
            arg_open = 1'b0;
            started_args = 0;
            expected_tokens.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            // Results show up only after their item has left the input register, so check before predicting.
            if (result_valid && !result_stall)
            begin
                if (expected_tokens.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result expected none actual kind %0d data %0d",
                             $time, kind, data);
                end
                else
                begin
                    oldest = expected_tokens.pop_front();
                    compare_field("kind", int'(oldest.kind), int'(kind));
                    compare_field("data", int'(oldest.data), int'(data));
                    compare_field("arg_index", int'(oldest.arg_index), int'(arg_index));
                    compare_field("first", int'(oldest.first), int'(first));
                    compare_field("arg_count", int'(oldest.arg_count), int'(arg_count));
                end
            end

            if (item_valid && !item_stall)
            begin
                if (tokenize(op, ch, next_token))
                    expected_tokens.push_back(next_token);
            end

            // Register writes only happen while the block is idle.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    qat_pkg::CFG_ESCAPE_CHAR: escape_byte = cfg_data;
                    qat_pkg::CFG_QUOTE_CHAR:  quote_byte = cfg_data;
                    default:                  ;
                endcase
            end

            pending = expected_tokens.size();
        end
    end

endmodule

>>> tb/tb_quoted_argument_tokenizer_unit.sv
// Testbench top for the quoted argument tokenizer: clock, reset, stimulus and verdict.
module tb_quoted_argument_tokenizer_unit;

    localparam int ITEM_TARGET  = 1750;
    localparam int PHASES       = 5;
    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 1000000;

    logic                            clk;
    logic                            rst_n;
    logic                            item_valid;
    logic                            item_stall;
    logic                            op;
    logic [7:0]                      ch;
    logic                            result_valid;
    logic                            result_stall;
    logic [1:0]                      kind;
    logic [7:0]                      data;
    logic [3:0]                      arg_index;
    logic                            first;
    logic [4:0]                      arg_count;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [qat_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]                      cfg_data;
    int                              fail_count;
    int                              pending;

    // Current register settings, used to shape well-formed lines.
    logic [7:0] esc_now;
    logic [7:0] quote_now;
    int         items_sent;
    int         cycles;
    bit         calm;
    bit         hold_req;

    quoted_argument_tokenizer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .op           (op),
        .ch           (ch),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .data         (data),
        .arg_index    (arg_index),
        .first        (first),
        .arg_count    (arg_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    tokenizer_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .op           (op),
        .ch           (ch),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .data         (data),
        .arg_index    (arg_index),
        .first        (first),
        .arg_count    (arg_count),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Cycle counter and timeout.
    initial cycles = 0;
    always @(posedge clk)
        cycles <= cycles + 1;

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("quoted_argument_tokenizer_unit: mismatch");
        $finish;
    end

    // Mostly no gap, some short ones, a few long ones.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Result-side stalls; a hold request freezes the receiver for a long stretch.
    initial
    begin
        int run_len;
        int stall_len;
        run_len = 0;
        stall_len = 0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                result_stall <= 1'b0;
            end
            else if (calm)
                result_stall <= 1'b0;
            else if (stall_len > 0)
            begin
                result_stall <= 1'b1;
                stall_len--;
            end
            else if (run_len > 0)
            begin
                result_stall <= 1'b0;
                run_len--;
            end
            else
            begin
                run_len = $urandom_range(0, 10);
                stall_len = pick_gap();
                result_stall <= 1'b0;
            end
        end
    end

    // Offers one transaction and waits until it is taken; starts and ends at a falling edge.
    task automatic send_item(input logic o, input logic [7:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        op <= o;
        ch <= c;
        do @(posedge clk); while (item_stall);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic send_char(input logic [7:0] c);
        send_item(qat_pkg::OP_CHAR, c);
    endtask

    task automatic end_line();
        logic [7:0] junk;
        junk = 8'($urandom_range(0, 255));
        send_item(qat_pkg::OP_LINE_END, junk);
    endtask

    // Stops offering, waits for all results, then lets in-flight silent items settle.
    task automatic drain();
        item_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // Writes both registers while idle.
    task automatic configure(input logic [7:0] e, input logic [7:0] q);
        cfg_valid <= 1'b1;
        cfg_index <= qat_pkg::CFG_ESCAPE_CHAR;
        cfg_data <= e;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_index <= qat_pkg::CFG_QUOTE_CHAR;
        cfg_data <= q;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        esc_now = e;
        quote_now = q;
    endtask

    function automatic logic [7:0] pick_blank();
        int r;
        r = $urandom_range(0, 5);
        return (r == 5) ? 8'd32 : 8'(9 + r);
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    // A byte that is neither blank nor one of the delimiters.
    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (is_blank(c) || c == esc_now || c == quote_now);
        return c;
    endfunction

    // A byte that is literal inside quotes.
    function automatic logic [7:0] pick_inner();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == esc_now || c == quote_now);
        return c;
    endfunction

    // One line: mostly well-formed arguments with random content, sometimes noise.
    task automatic random_line();
        int         n_args;
        int         n_pieces;
        int         n_inner;
        int         r;
        logic [7:0] c;
        if ($urandom_range(0, 9) == 0)
        begin
            // Noise: raw bytes, delimiters anywhere, line end optional.
            n_args = $urandom_range(0, 12);
            repeat (n_args)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    c = esc_now;
                else if (r == 1)
                    c = quote_now;
                else if (r == 2)
                    c = pick_blank();
                else
                    c = 8'($urandom_range(0, 255));
                send_char(c);
            end
            if ($urandom_range(0, 1) == 1)
                end_line();
            return;
        end

        // Many lines stay short; the rest are long, and some pass the argument limit.
        n_args = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 6) : $urandom_range(10, 20);
        repeat (n_args)
        begin
            repeat ($urandom_range(0, 2)) send_char(pick_blank());
            n_pieces = $urandom_range(1, 3);
            repeat (n_pieces)
            begin
                r = $urandom_range(0, 9);
                if (r < 5)
                    send_char(pick_plain());
                else if (r < 7)
                begin
                    send_char(esc_now);
                    c = 8'($urandom_range(0, 255));
                    send_char(c);
                end
                else if (r < 9)
                begin
                    send_char(quote_now);
                    n_inner = $urandom_range(0, 4);
                    repeat (n_inner)
                    begin
                        if ($urandom_range(0, 4) == 0)
                        begin
                            send_char(esc_now);
                            c = 8'($urandom_range(0, 255));
                            send_char(c);
                        end
                        else
                            send_char(pick_inner());
                    end
                    send_char(quote_now);
                end
                else
                begin
                    send_char(quote_now);
                    send_char(quote_now);
                end
            end
            send_char(pick_blank());
        end
        end_line();
    endtask

    // Stimulus: directed lines with reset settings, then random phases over several settings.
    initial
    begin
        logic [7:0] esc_set[PHASES];
        logic [7:0] quote_set[PHASES];
        int         goal;
        rst_n = 1'b0;
        item_valid = 1'b0;
        op = qat_pkg::OP_CHAR;
        ch = 8'd0;
        cfg_valid = 1'b0;
        cfg_index = qat_pkg::CFG_ESCAPE_CHAR;
        cfg_data = 8'd0;
        calm = 1'b0;
        hold_req = 1'b0;
        items_sent = 0;
        esc_now = qat_pkg::ESCAPE_CHAR_RESET;
        quote_now = qat_pkg::QUOTE_CHAR_RESET;

        esc_set[0] = 8'd0;
        quote_set[0] = 8'd255;
        esc_set[1] = 8'd255;
        quote_set[1] = 8'd0;
        esc_set[2] = 8'd39;
        quote_set[2] = 8'd39;
        esc_set[3] = 8'($urandom_range(0, 255));
        quote_set[3] = 8'($urandom_range(0, 255));
        esc_set[4] = qat_pkg::ESCAPE_CHAR_RESET;
        quote_set[4] = qat_pkg::QUOTE_CHAR_RESET;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty line, then a blank that closes nothing.
        send_item(qat_pkg::OP_LINE_END, 8'hFF);
        send_char(8'd32);
        // Extreme bytes in a plain argument closed by a tab.
        send_char(8'h61);
        send_char(8'hFF);
        send_char(8'h00);
        send_char(8'd9);
        // Escaped quote at the very start of quoted text, then a quoted blank.
        send_char(qat_pkg::QUOTE_CHAR_RESET);
        send_char(qat_pkg::ESCAPE_CHAR_RESET);
        send_char(qat_pkg::QUOTE_CHAR_RESET);
        send_char(8'd32);
        send_char(qat_pkg::QUOTE_CHAR_RESET);
        // Close with a carriage return; empty quotes start nothing.
        send_char(8'd13);
        send_char(qat_pkg::QUOTE_CHAR_RESET);
        send_char(qat_pkg::QUOTE_CHAR_RESET);
        send_char(8'd32);
        // Escaped blank opens an argument; escaped escape is literal.
        send_char(qat_pkg::ESCAPE_CHAR_RESET);
        send_char(8'd32);
        send_char(qat_pkg::ESCAPE_CHAR_RESET);
        send_char(qat_pkg::ESCAPE_CHAR_RESET);
        end_line();
        // Open quote with a dangling escape dropped at line end.
        send_char(qat_pkg::QUOTE_CHAR_RESET);
        send_char(8'h71);
        send_char(qat_pkg::ESCAPE_CHAR_RESET);
        send_item(qat_pkg::OP_LINE_END, 8'h00);
        // Dangling escape outside quotes.
        send_char(qat_pkg::ESCAPE_CHAR_RESET);
        end_line();
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            configure(esc_set[p], quote_set[p]);
            goal = items_sent + ITEM_TARGET / PHASES;
            calm = (p == 3);
            // Receiver holds off once while lines keep coming, filling the block.
            if (p == 0)
                hold_req = 1'b1;
            while (items_sent < goal)
                random_line();
            end_line();
            calm = 1'b0;
            drain();
        end

        if (fail_count == 0)
            $display("quoted_argument_tokenizer_unit: match");
        else
            $display("quoted_argument_tokenizer_unit: mismatch");
        $finish;
    end

endmodule
